// ===== hdl/ycwt_pkg.sv =====
package ycwt_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MASK_X   = 3'd0,
        REG_MASK_Y   = 3'd1,
        REG_IR_MODE  = 3'd2,
        REG_CR_UPPER = 3'd3,
        REG_CR_LOWER = 3'd4,
        REG_CB_UPPER = 3'd5,
        REG_CB_LOWER = 3'd6
    } cfg_reg_t;

    // pixel and threshold widths
    localparam int PIX_BITS = 8;
    localparam int VAL_BITS = 8;

    // biased dot product: always 0 .. 2399960, fits 22 bits unsigned
    localparam int SUM_BITS = 22;
    typedef logic [SUM_BITS-1:0] sum_t;

    // coefficients scaled by 10000
    localparam sum_t K_CR_R = 22'd4392;
    localparam sum_t K_CR_G = 22'd3678;
    localparam sum_t K_CR_B = 22'd714;
    localparam sum_t K_CB_R = 22'd1482;
    localparam sum_t K_CB_G = 22'd2910;
    localparam sum_t K_CB_B = 22'd4392;
    localparam sum_t K_Y_R  = 22'd2566;
    localparam sum_t K_Y_G  = 22'd5046;
    localparam sum_t K_Y_B  = 22'd978;

    // offsets times 10000
    localparam sum_t OFS_CHROMA = 22'd1280000;
    localparam sum_t OFS_LUMA   = 22'd160000;

    // floor(x / 10000) as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^22
    localparam int   RECIP_BITS  = 23;
    localparam int   RECIP_SHIFT = 36;
    localparam int   PROD_BITS   = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP = 23'd6871948;

    // threshold reset values
    localparam logic [VAL_BITS-1:0] CR_UPPER_RST = 8'd250;
    localparam logic [VAL_BITS-1:0] CR_LOWER_RST = 8'd230;
    localparam logic [VAL_BITS-1:0] CB_UPPER_RST = 8'd100;
    localparam logic [VAL_BITS-1:0] CB_LOWER_RST = 8'd80;

    // stage 1 to stage 2 payload
    typedef struct packed {
        sum_t sum_a;
        sum_t sum_b;
        logic masked;
    } sums_t;

    // stage 2 to stage 3 payload
    typedef struct packed {
        logic [VAL_BITS-1:0] val_a;
        logic [VAL_BITS-1:0] val_b;
        logic                masked;
    } vals_t;

    // window settings
    typedef struct packed {
        logic                ir_mode;
        logic [VAL_BITS-1:0] cr_upper;
        logic [VAL_BITS-1:0] cr_lower;
        logic [VAL_BITS-1:0] cb_upper;
        logic [VAL_BITS-1:0] cb_lower;
    } window_cfg_t;

endpackage

// ===== hdl/ycwt_dot.sv =====
module ycwt_dot #(
    parameter int COORD_BITS = ycwt_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ycwt_pkg::PIX_BITS-1:0] red,
    input  logic [ycwt_pkg::PIX_BITS-1:0] green,
    input  logic [ycwt_pkg::PIX_BITS-1:0] blue,
    input  logic [COORD_BITS-1:0]         column,
    input  logic [COORD_BITS-1:0]         line,
    input  logic [2*COORD_BITS-1:0]       mask_x_range,
    input  logic [2*COORD_BITS-1:0]       mask_y_range,
    input  logic                          ir_mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ycwt_pkg::sums_t               out_data
);
    import ycwt_pkg::*;

    logic              valid_reg;
    sums_t             data_reg;
    sums_t             data_next;
    logic              en;
    logic [COORD_BITS:0] col_inc;
    logic [COORD_BITS:0] line_inc;
    logic              in_x;
    logic              in_y;
    sum_t              r_ext;
    sum_t              g_ext;
    sum_t              b_ext;
    sum_t              cr_sum;
    sum_t              cb_sum;
    sum_t              y_sum;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // mask rectangle test, one-based minimum and exclusive maximum
    assign col_inc  = {1'b0, column} + {{COORD_BITS{1'b0}}, 1'b1};
    assign line_inc = {1'b0, line} + {{COORD_BITS{1'b0}}, 1'b1};
    assign in_x = (col_inc >= {1'b0, mask_x_range[COORD_BITS-1:0]})
               && (column < mask_x_range[2*COORD_BITS-1:COORD_BITS]);
    assign in_y = (line_inc >= {1'b0, mask_y_range[COORD_BITS-1:0]})
               && (line < mask_y_range[2*COORD_BITS-1:COORD_BITS]);

    // biased dot products, never negative so modulo arithmetic is exact
    assign r_ext  = SUM_BITS'(red);
    assign g_ext  = SUM_BITS'(green);
    assign b_ext  = SUM_BITS'(blue);
    assign cr_sum = OFS_CHROMA + K_CR_R * r_ext - K_CR_G * g_ext - K_CR_B * b_ext;
    assign cb_sum = OFS_CHROMA + K_CB_B * b_ext - K_CB_R * r_ext - K_CB_G * g_ext;
    assign y_sum  = OFS_LUMA + K_Y_R * r_ext + K_Y_G * g_ext + K_Y_B * b_ext;

    always_comb
    begin
        data_next.sum_a  = ir_mode ? y_sum : cr_sum;
        data_next.sum_b  = cb_sum;
        data_next.masked = in_x && in_y;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/ycwt_div.sv =====
module ycwt_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ycwt_pkg::sums_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ycwt_pkg::vals_t out_data
);
    import ycwt_pkg::*;

    logic                 valid_reg;
    vals_t                data_reg;
    vals_t                data_next;
    logic                 en;
    logic [PROD_BITS-1:0] prod_a;
    logic [PROD_BITS-1:0] prod_b;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // divide by 10000 through the reciprocal, the offset is already folded in
    assign prod_a = PROD_BITS'(in_data.sum_a) * PROD_BITS'(RECIP);
    assign prod_b = PROD_BITS'(in_data.sum_b) * PROD_BITS'(RECIP);

    always_comb
    begin
        data_next.val_a  = prod_a[RECIP_SHIFT+VAL_BITS-1:RECIP_SHIFT];
        data_next.val_b  = prod_b[RECIP_SHIFT+VAL_BITS-1:RECIP_SHIFT];
        data_next.masked = in_data.masked;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/ycwt_window.sv =====
module ycwt_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ycwt_pkg::vals_t       in_data,
    input  ycwt_pkg::window_cfg_t win_cfg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  foreground,
    output logic                  masked
);
    import ycwt_pkg::*;

    logic valid_reg;
    logic fg_reg;
    logic fg_next;
    logic masked_reg;
    logic en;
    logic a_pass;
    logic b_pass;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // inclusive window tests, cb window ignored in ir mode
    assign a_pass  = (in_data.val_a <= win_cfg.cr_upper) && (in_data.val_a >= win_cfg.cr_lower);
    assign b_pass  = (in_data.val_b <= win_cfg.cb_upper) && (in_data.val_b >= win_cfg.cb_lower);
    assign fg_next = !in_data.masked && a_pass && (win_cfg.ir_mode || b_pass);

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            fg_reg     <= fg_next;
            masked_reg <= in_data.masked;
        end
    end

    assign out_valid  = valid_reg;
    assign foreground = fg_reg;
    assign masked     = masked_reg;

endmodule

// ===== hdl/ycbcr_color_window_threshold.sv =====
// pipeline: a pixel transaction passes through three register stages, dot
//   product, reciprocal multiply and window compare, to the result output
// throughput: one pixel per cycle while result_ready holds no back-pressure,
//   set by each of those stages taking a new pixel every clock unless stalled
// reset: rst_n clears all stage valid bits at once; mask ranges and ir mode
//   reset to 0, windows to cr 230..250 and cb 80..100
module ycbcr_color_window_threshold #(
    parameter int COORD_BITS = ycwt_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ycwt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [2*COORD_BITS-1:0]             cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic [ycwt_pkg::PIX_BITS-1:0]       red,
    input  logic [ycwt_pkg::PIX_BITS-1:0]       green,
    input  logic [ycwt_pkg::PIX_BITS-1:0]       blue,
    input  logic [COORD_BITS-1:0]               column,
    input  logic [COORD_BITS-1:0]               line,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                foreground,
    output logic                                masked
);
    import ycwt_pkg::*;

    logic [2*COORD_BITS-1:0] mask_x_reg;
    logic [2*COORD_BITS-1:0] mask_y_reg;
    window_cfg_t             win_reg;
    sums_t                   s1_data;
    vals_t                   s2_data;
    logic                    s1_valid;
    logic                    s1_ready;
    logic                    s2_valid;
    logic                    s2_ready;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_x_reg       <= '0;
            mask_y_reg       <= '0;
            win_reg.ir_mode  <= 1'b0;
            win_reg.cr_upper <= CR_UPPER_RST;
            win_reg.cr_lower <= CR_LOWER_RST;
            win_reg.cb_upper <= CB_UPPER_RST;
            win_reg.cb_lower <= CB_LOWER_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MASK_X:   mask_x_reg       <= cfg_data;
                REG_MASK_Y:   mask_y_reg       <= cfg_data;
                REG_IR_MODE:  win_reg.ir_mode  <= cfg_data[0];
                REG_CR_UPPER: win_reg.cr_upper <= cfg_data[VAL_BITS-1:0];
                REG_CR_LOWER: win_reg.cr_lower <= cfg_data[VAL_BITS-1:0];
                REG_CB_UPPER: win_reg.cb_upper <= cfg_data[VAL_BITS-1:0];
                REG_CB_LOWER: win_reg.cb_lower <= cfg_data[VAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: mask test and dot products
    ycwt_dot #(
        .COORD_BITS (COORD_BITS)
    ) u_dot (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixel_valid),
        .in_ready     (pixel_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .column       (column),
        .line         (line),
        .mask_x_range (mask_x_reg),
        .mask_y_range (mask_y_reg),
        .ir_mode      (win_reg.ir_mode),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .out_data     (s1_data)
    );

    // stage 2: scale down by 10000
    ycwt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // stage 3: window compare and output register
    ycwt_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_ready   (s2_ready),
        .in_data    (s2_data),
        .win_cfg    (win_reg),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .foreground (foreground),
        .masked     (masked)
    );

endmodule
